[rtl/core/tcw_pkg.sv]
`default_nettype none

package tcw_pkg;

  // Screen geometry
  localparam int SCREEN_WIDTH  = 80;
  localparam int SCREEN_HEIGHT = 25;
  localparam int CELL_COUNT    = SCREEN_WIDTH * SCREEN_HEIGHT;

  // Field widths
  localparam int CMD_W       = 2;
  localparam int CHAR_W      = 8;
  localparam int ATTR_W      = 8;
  localparam int CELL_W      = 16;
  localparam int CELL_ADDR_W = 11;
  localparam int ROW_W       = 5;
  localparam int COL_W       = 7;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;
  localparam logic [CELL_W-1:0] RESET_BLANK = {ATTR_RESET, CH_SPACE};

  // Configuration map
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_ATTRIBUTE = 1'b0;

  // Cursor and sweep limits
  localparam logic [ROW_W-1:0]       LAST_ROW   = ROW_W'(SCREEN_HEIGHT - 1);
  localparam logic [COL_W-1:0]       LINE_LEN   = COL_W'(SCREEN_WIDTH);
  localparam logic [CELL_ADDR_W-1:0] ROW_STRIDE = CELL_ADDR_W'(SCREEN_WIDTH);
  localparam logic [CELL_ADDR_W-1:0] LAST_CELL  = CELL_ADDR_W'(CELL_COUNT - 1);
  localparam logic [CELL_ADDR_W-1:0] LAST_ROW_BASE =
    CELL_ADDR_W'(CELL_COUNT - SCREEN_WIDTH);
  localparam logic [CELL_ADDR_W-1:0] CELL_LIMIT = CELL_ADDR_W'(CELL_COUNT);

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    OP_PUT,
    OP_LF,
    OP_CR,
    OP_CLEAR,
    OP_READ,
    OP_NOP
  } op_kind_t;

  typedef struct packed {
    op_kind_t                kind;
    logic [CHAR_W-1:0]       char_code;
    logic [CELL_ADDR_W-1:0]  cell_addr;
  } op_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_WRITE,
    ST_READ_WAIT,
    ST_FILL,
    ST_SCROLL_COPY,
    ST_SCROLL_BLANK,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

[rtl/core/tcw_ram.sv]
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/core/tcw_front.sv]
`default_nettype none

module tcw_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        enable,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [tcw_pkg::CMD_W-1:0]   cmd,
  input  wire logic [tcw_pkg::CHAR_W-1:0]  char_code,
  input  wire logic [tcw_pkg::CELL_ADDR_W-1:0] cell_addr,
  output logic                             op_valid,
  input  wire logic                        op_ready,
  output tcw_pkg::op_t                     op
);

  import tcw_pkg::*;

  op_t                    entry;
  op_t                    queue [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   push;
  logic                   pop;

  // Classify the incoming command
  always_comb begin
    entry.char_code = char_code;
    entry.cell_addr = cell_addr;
    case (cmd)
      CMD_PUT: begin
        if (char_code == CH_LF) begin
          entry.kind = OP_LF;
        end else if (char_code == CH_CR) begin
          entry.kind = OP_CR;
        end else begin
          entry.kind = OP_PUT;
        end
      end
      CMD_CLEAR: entry.kind = OP_CLEAR;
      CMD_READ:  entry.kind = (cell_addr < CELL_LIMIT) ? OP_READ : OP_NOP;
      default:   entry.kind = OP_NOP;
    endcase
  end

  assign in_ready = enable && (count != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign op_valid = (count != '0);
  assign pop      = op_valid && op_ready;
  assign op       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= entry;
    end
  end

endmodule

`default_nettype wire

[rtl/core/tcw_back.sv]
`default_nettype none

module tcw_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [tcw_pkg::ATTR_W-1:0]   attribute,
  input  wire logic                         op_valid,
  output logic                              op_ready,
  input  wire tcw_pkg::op_t                 op,
  output logic                              init_done,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [tcw_pkg::ROW_W-1:0]         cursor_row,
  output logic [tcw_pkg::COL_W-1:0]         cursor_col,
  output logic [tcw_pkg::CELL_W-1:0]        cell_data
);

  import tcw_pkg::*;

  state_t                  state;
  state_t                  state_next;
  logic [CELL_ADDR_W-1:0]  cnt;
  logic [CELL_ADDR_W-1:0]  cnt_next;
  logic [ROW_W-1:0]        row;
  logic [ROW_W-1:0]        row_next;
  logic [COL_W-1:0]        col;
  logic [COL_W-1:0]        col_next;
  logic [CELL_ADDR_W-1:0]  row_base;
  logic [CELL_ADDR_W-1:0]  row_base_next;
  logic                    pend_write;
  logic                    pend_write_next;
  logic [CHAR_W-1:0]       char_reg;
  logic [CELL_W-1:0]       data_reg;
  logic [CELL_W-1:0]       data_reg_next;
  logic                    out_free;
  logic                    emit;
  logic [CELL_ADDR_W-1:0]  cur_addr;
  logic [CELL_W-1:0]       blank;

  logic                    ram_we;
  logic [CELL_ADDR_W-1:0]  ram_waddr;
  logic [CELL_W-1:0]       ram_wdata;
  logic [CELL_ADDR_W-1:0]  ram_raddr;
  logic [CELL_W-1:0]       ram_rdata;

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free  = !out_valid || out_ready;
  assign emit      = (state == ST_DONE) && out_free;
  assign cur_addr  = row_base + CELL_ADDR_W'(col);
  assign blank     = {attribute, CH_SPACE};
  assign init_done = (state != ST_INIT);
  assign op_ready  = (state == ST_IDLE);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        if (cnt == LAST_CELL) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (op_valid) begin
          case (op.kind)
            OP_PUT: begin
              if (col >= LINE_LEN) begin
                state_next = (row < LAST_ROW) ? ST_WRITE : ST_SCROLL_COPY;
              end else begin
                state_next = ST_DONE;
              end
            end
            OP_LF:    state_next = (row < LAST_ROW) ? ST_DONE : ST_SCROLL_COPY;
            OP_CLEAR: state_next = ST_FILL;
            OP_READ:  state_next = ST_READ_WAIT;
            default:  state_next = ST_DONE;
          endcase
        end
      end
      ST_WRITE:     state_next = ST_DONE;
      ST_READ_WAIT: state_next = ST_DONE;
      ST_FILL: begin
        if (cnt == LAST_CELL) begin
          state_next = ST_DONE;
        end
      end
      ST_SCROLL_COPY: begin
        if (cnt == LAST_ROW_BASE) begin
          state_next = ST_SCROLL_BLANK;
        end
      end
      ST_SCROLL_BLANK: begin
        if (cnt == LAST_CELL) begin
          state_next = pend_write ? ST_WRITE : ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath and screen port
  always_comb begin
    cnt_next        = cnt;
    row_next        = row;
    col_next        = col;
    row_base_next   = row_base;
    pend_write_next = pend_write;
    data_reg_next   = data_reg;
    ram_we          = 1'b0;
    ram_waddr       = cur_addr;
    ram_wdata       = {attribute, char_reg};
    ram_raddr       = op.cell_addr;
    case (state)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = cnt;
        ram_wdata = RESET_BLANK;
        cnt_next  = cnt + 1'b1;
      end
      ST_IDLE: begin
        if (op_valid) begin
          data_reg_next = '0;
          cnt_next      = '0;
          case (op.kind)
            OP_PUT: begin
              if (col >= LINE_LEN) begin
                col_next = '0;
                if (row < LAST_ROW) begin
                  row_next      = row + 1'b1;
                  row_base_next = row_base + ROW_STRIDE;
                end else begin
                  pend_write_next = 1'b1;
                end
              end else begin
                ram_we    = 1'b1;
                ram_wdata = {attribute, op.char_code};
                col_next  = col + 1'b1;
              end
            end
            OP_LF: begin
              col_next = '0;
              if (row < LAST_ROW) begin
                row_next      = row + 1'b1;
                row_base_next = row_base + ROW_STRIDE;
              end else begin
                pend_write_next = 1'b0;
              end
            end
            OP_CR: col_next = '0;
            OP_CLEAR: begin
              row_next      = '0;
              col_next      = '0;
              row_base_next = '0;
            end
            default: ;
          endcase
        end
      end
      ST_WRITE: begin
        ram_we   = 1'b1;
        col_next = col + 1'b1;
      end
      ST_READ_WAIT: data_reg_next = ram_rdata;
      ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = cnt;
        ram_wdata = blank;
        cnt_next  = cnt + 1'b1;
      end
      ST_SCROLL_COPY: begin
        // Read one row ahead, write the previous cycle's read one slot behind
        ram_raddr = cnt + ROW_STRIDE;
        ram_we    = (cnt != '0);
        ram_waddr = cnt - 1'b1;
        ram_wdata = ram_rdata;
        if (cnt != LAST_ROW_BASE) begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_SCROLL_BLANK: begin
        ram_we    = 1'b1;
        ram_waddr = cnt;
        ram_wdata = blank;
        cnt_next  = cnt + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      cnt        <= '0;
      row        <= '0;
      col        <= '0;
      row_base   <= '0;
      pend_write <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      cnt        <= cnt_next;
      row        <= row_next;
      col        <= col_next;
      row_base   <= row_base_next;
      pend_write <= pend_write_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_reg <= data_reg_next;
    if ((state == ST_IDLE) && op_valid) begin
      char_reg <= op.char_code;
    end
    if (emit) begin
      cursor_row <= row;
      cursor_col <= col;
      cell_data  <= data_reg;
    end
  end

endmodule

`default_nettype wire

[rtl/core/text_console_writer.sv]
// Flow: every command passes through the back end's dispatch and result states; an in-range
// cell read adds a wait state for the screen RAM, and a put that wraps to the next row adds a
// write state. A scroll copies each row up by one and then blanks the last row; a clear blanks
// every cell. The back end takes a new command only once its last result can be handed on;
// meanwhile the front end queues up to two further commands.
// Reset: cursor home, attribute 0x07, then a blanking pass over the screen with in_ready low.
`default_nettype none

module text_console_writer (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // Command channel
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [tcw_pkg::CMD_W-1:0]        cmd,
  input  wire logic [tcw_pkg::CHAR_W-1:0]       char_code,
  input  wire logic [tcw_pkg::CELL_ADDR_W-1:0]  cell_addr,
  // Result channel
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [tcw_pkg::ROW_W-1:0]             cursor_row,
  output logic [tcw_pkg::COL_W-1:0]             cursor_col,
  output logic [tcw_pkg::CELL_W-1:0]            cell_data,
  // Configuration port
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [tcw_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [tcw_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [tcw_pkg::APB_DATA_W-1:0]        prdata,
  output logic                                  pready
);

  import tcw_pkg::*;

  logic [ATTR_W-1:0] attribute;
  logic              cfg_write;
  logic              init_done;
  logic              op_valid;
  logic              op_ready;
  op_t               op;

  // Configuration: one register, the attribute byte, at byte address 0.
  // Word index is paddr[2]; anything past the attribute is ignored on write
  // and reads as zero.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      attribute <= ATTR_RESET;
    end else if (cfg_write && (paddr[2] == REG_ATTRIBUTE)) begin
      attribute <= pwdata[ATTR_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_ATTRIBUTE) begin
      prdata = APB_DATA_W'(attribute);
    end
  end

  // Front end: classify each command transaction and hold it in a short
  // queue; stall the input while the screen is being cleared after reset.
  tcw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .enable    (init_done),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .char_code (char_code),
    .cell_addr (cell_addr),
    .op_valid  (op_valid),
    .op_ready  (op_ready),
    .op        (op)
  );

  // Back end: own the cursor and the screen RAM, run writes, reads, scrolls
  // and clears, and hold each result in an output register until taken.
  tcw_back u_back (
    .clk        (clk),
    .rst        (rst),
    .attribute  (attribute),
    .op_valid   (op_valid),
    .op_ready   (op_ready),
    .op         (op),
    .init_done  (init_done),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cursor_row (cursor_row),
    .cursor_col (cursor_col),
    .cell_data  (cell_data)
  );

endmodule

`default_nettype wire
